// ===== design/tsai_pkg.sv =====
// ---------------------------------------------------------------------------
// tsai_pkg: shared types and constants
// Sample and point payloads, controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package tsai_pkg;

    localparam int TIME_W      = 63;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = TIME_W + VAL_W;
    localparam int MAX_RESULTS = 32;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic                    channel;
        logic [TIME_W-1:0]       sample_time;
        logic signed [VAL_W-1:0] sample_value;
    } sample_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
        logic                    last_point;
    } point_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // store the incoming request
        logic rd_en;    // read one queue entry
        logic rd_ch;    // 0 x queue, 1 y queue
        logic rd_nxt;   // 0 head entry, 1 entry after head
        logic pop_x;
        logic pop_y;
        logic start;    // launch interpolation
        logic side;     // 0 pair x head, 1 pair y head
        logic take;     // capture interpolated point
        logic flush;    // send pending point as last
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic x_gt1;
        logic y_gt1;
        logic x1_lt_y0;
        logic y1_lt_x0;
        logic x0_ge_y0;
        logic y0_ge_x0;
        logic done;
        logic out_free;
        logic pend_valid;
    } stat_t;

endpackage

// ===== design/tsai_interp.sv =====
// ---------------------------------------------------------------------------
// tsai_interp: iterative linear interpolation unit
// v1 + sign(dv) * round(|dv| * (t - t1) / (t2 - t1)), t clamped to [t1, t2],
// saturated, using a 32x32 and a 32x31 partial product and a restoring divider one bit per cycle.
// ---------------------------------------------------------------------------
module tsai_interp (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [tsai_pkg::VAL_W-1:0]         v1,
    input  logic signed [tsai_pkg::VAL_W-1:0]         v2,
    input  logic        [tsai_pkg::TIME_W-1:0]        t1,
    input  logic        [tsai_pkg::TIME_W-1:0]        t2,
    input  logic        [tsai_pkg::TIME_W-1:0]        t,
    output logic                                      done,
    output logic signed [tsai_pkg::VAL_W-1:0]         result
);

    localparam int TW = tsai_pkg::TIME_W;
    localparam int VW = tsai_pkg::VAL_W;
    localparam int PW = tsai_pkg::PROD_W;
    localparam int CW = $clog2(PW);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CLAMP = 3'd1;
    localparam logic [2:0] PH_MUL1  = 3'd2;
    localparam logic [2:0] PH_MUL2  = 3'd3;
    localparam logic [2:0] PH_ADD   = 3'd4;
    localparam logic [2:0] PH_DIV   = 3'd5;
    localparam logic [2:0] PH_RND   = 3'd6;
    localparam logic [2:0] PH_OUT   = 3'd7;

    logic [2:0]                 ph_reg, ph_next;
    logic                       done_reg, done_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [TW-1:0]              den_reg, den_next;
    logic [TW-1:0]              num_reg, num_next;
    logic [VW-1:0]              mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic signed [VW-1:0]       v1_reg, v1_next;
    logic [2*VW-1:0]            p1_reg, p1_next;
    logic [2*VW-2:0]            p2_reg, p2_next;
    logic [PW-1:0]              acc_reg, acc_next;
    logic [TW-1:0]              rem_reg, rem_next;
    logic [VW:0]                q_reg, q_next;
    logic signed [VW-1:0]       res_reg, res_next;

    logic signed [VW:0]         dv;
    logic [TW:0]                rem_sh;
    logic signed [VW+2:0]       sum;

    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        v1_next   = v1_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        dv        = {v2[VW-1], v2} - {v1[VW-1], v1};
        rem_sh    = {rem_reg, acc_reg[PW-1]};
        sum       = '0;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b0;
                    den_next  = t2 - t1;
                    num_next  = (t > t1) ? (t - t1) : '0;
                    zero_next = (t2 <= t1);
                    neg_next  = dv[VW];
                    mag_next  = dv[VW] ? VW'(-dv) : VW'(dv);
                    v1_next   = v1;
                    ph_next   = PH_CLAMP;
                end
            end
            PH_CLAMP:
            begin
                if (num_reg > den_reg)
                    num_next = den_reg;
                ph_next = PH_MUL1;
            end
            PH_MUL1:
            begin
                p1_next = mag_reg * num_reg[VW-1:0];
                ph_next = PH_MUL2;
            end
            PH_MUL2:
            begin
                p2_next = mag_reg * num_reg[TW-1:VW];
                ph_next = PH_ADD;
            end
            PH_ADD:
            begin
                acc_next = PW'(p1_reg) + {p2_reg, {VW{1'b0}}};
                rem_next = '0;
                q_next   = '0;
                cnt_next = CW'(PW - 1);
                ph_next  = PH_DIV;
            end
            PH_DIV:
            begin
                // shift in one dividend bit, subtract when it fits
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = TW'(rem_sh - {1'b0, den_reg});
                    q_next   = {q_reg[VW-1:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[TW-1:0];
                    q_next   = {q_reg[VW-1:0], 1'b0};
                end
                acc_next = {acc_reg[PW-2:0], 1'b0};
                if (cnt_reg == '0)
                    ph_next = PH_RND;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            PH_RND:
            begin
                // round half away from zero
                if (rem_reg >= den_reg - rem_reg)
                    q_next = q_reg + 1'b1;
                ph_next = PH_OUT;
            end
            PH_OUT:
            begin
                if (neg_reg)
                    sum = (VW+3)'(v1_reg) - $signed({2'b00, q_reg});
                else
                    sum = (VW+3)'(v1_reg) + $signed({2'b00, q_reg});
                if (zero_reg)
                    res_next = v1_reg;
                else if (sum > 35'sd2147483647)
                    res_next = 32'sh7fffffff;
                else if (sum < -35'sd2147483648)
                    res_next = 32'sh80000000;
                else
                    res_next = sum[VW-1:0];
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        v1_reg   <= v1_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

endmodule

// ===== design/tsai_dpath.sv =====
// ---------------------------------------------------------------------------
// tsai_dpath: queues, head registers, interpolation and output stage
// Circular queue memories per channel, cached head entries, pending point
// and the output register.
// ---------------------------------------------------------------------------
module tsai_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsai_pkg::sample_t   sample,
    input  tsai_pkg::cmd_t      cmd,
    output tsai_pkg::stat_t     stat,
    output tsai_pkg::point_t    point,
    output logic                point_valid,
    input  logic                point_stall
);

    localparam int TW = tsai_pkg::TIME_W;
    localparam int VW = tsai_pkg::VAL_W;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(QUEUE_DEPTH);

    logic [TW-1:0]        xt_mem [QUEUE_DEPTH];
    logic [VW-1:0]        xv_mem [QUEUE_DEPTH];
    logic [TW-1:0]        yt_mem [QUEUE_DEPTH];
    logic [VW-1:0]        yv_mem [QUEUE_DEPTH];

    logic [AW-1:0]        xhead_reg, xhead_next, xtail_reg, xtail_next;
    logic [AW-1:0]        yhead_reg, yhead_next, ytail_reg, ytail_next;
    logic [NW-1:0]        xcnt_reg, xcnt_next, ycnt_reg, ycnt_next;
    logic [TW-1:0]        xlast_reg, xlast_next, ylast_reg, ylast_next;

    logic [TW-1:0]        rdt_reg;
    logic [VW-1:0]        rdv_reg;
    logic                 ld_reg, ld_ch_reg, ld_nxt_reg;

    logic [TW-1:0]        x0t_reg, x1t_reg, y0t_reg, y1t_reg;
    logic [VW-1:0]        x0v_reg, x1v_reg, y0v_reg, y1v_reg;

    logic                 pend_valid_reg, pend_valid_next;
    logic [VW-1:0]        pend_x_reg, pend_y_reg, keep_reg;
    logic                 side_reg;
    logic                 out_valid_reg, out_valid_next;
    tsai_pkg::point_t     out_reg;

    logic                 clr, full;
    logic [AW-1:0]        rd_addr;
    logic                 i_done;
    logic signed [VW-1:0] i_res;
    logic                 out_free;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign out_free = !out_valid_reg || !point_stall;

    // queue pointer update on accept and pop
    always_comb
    begin
        xhead_next = xhead_reg;
        xtail_next = xtail_reg;
        xcnt_next  = xcnt_reg;
        xlast_next = xlast_reg;
        yhead_next = yhead_reg;
        ytail_next = ytail_reg;
        ycnt_next  = ycnt_reg;
        ylast_next = ylast_reg;
        clr  = 1'b0;
        full = 1'b0;
        if (cmd.accept)
        begin
            if (!sample.channel)
            begin
                clr  = (xcnt_reg != '0) && (sample.sample_time <= xlast_reg);
                full = xcnt_reg == FULL_CNT;
                xtail_next = inc(xtail_reg);
                xlast_next = sample.sample_time;
                if (clr)
                begin
                    xhead_next = xtail_reg;
                    xcnt_next  = NW'(1);
                end
                else if (full)
                    xhead_next = inc(xhead_reg);
                else
                    xcnt_next = xcnt_reg + 1'b1;
            end
            else
            begin
                clr  = (ycnt_reg != '0) && (sample.sample_time <= ylast_reg);
                full = ycnt_reg == FULL_CNT;
                ytail_next = inc(ytail_reg);
                ylast_next = sample.sample_time;
                if (clr)
                begin
                    yhead_next = ytail_reg;
                    ycnt_next  = NW'(1);
                end
                else if (full)
                    yhead_next = inc(yhead_reg);
                else
                    ycnt_next = ycnt_reg + 1'b1;
            end
        end
        if (cmd.pop_x)
        begin
            xhead_next = inc(xhead_reg);
            xcnt_next  = xcnt_reg - 1'b1;
        end
        if (cmd.pop_y)
        begin
            yhead_next = inc(yhead_reg);
            ycnt_next  = ycnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xhead_reg <= '0;
            xtail_reg <= '0;
            xcnt_reg  <= '0;
            yhead_reg <= '0;
            ytail_reg <= '0;
            ycnt_reg  <= '0;
        end
        else
        begin
            xhead_reg <= xhead_next;
            xtail_reg <= xtail_next;
            xcnt_reg  <= xcnt_next;
            yhead_reg <= yhead_next;
            ytail_reg <= ytail_next;
            ycnt_reg  <= ycnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xlast_reg <= xlast_next;
        ylast_reg <= ylast_next;
    end

    // queue memories
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !sample.channel)
        begin
            xt_mem[xtail_reg] <= sample.sample_time;
            xv_mem[xtail_reg] <= sample.sample_value;
        end
        if (cmd.accept && sample.channel)
        begin
            yt_mem[ytail_reg] <= sample.sample_time;
            yv_mem[ytail_reg] <= sample.sample_value;
        end
    end

    always_comb
    begin
        if (!cmd.rd_ch)
            rd_addr = cmd.rd_nxt ? inc(xhead_reg) : xhead_reg;
        else
            rd_addr = cmd.rd_nxt ? inc(yhead_reg) : yhead_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            if (!cmd.rd_ch)
            begin
                rdt_reg <= xt_mem[rd_addr];
                rdv_reg <= xv_mem[rd_addr];
            end
            else
            begin
                rdt_reg <= yt_mem[rd_addr];
                rdv_reg <= yv_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_reg <= 1'b0;
        else
            ld_reg <= cmd.rd_en;
    end

    // capture read data into the head registers
    always_ff @(posedge clk)
    begin
        ld_ch_reg  <= cmd.rd_ch;
        ld_nxt_reg <= cmd.rd_nxt;
        if (ld_reg)
        begin
            case ({ld_ch_reg, ld_nxt_reg})
                2'b00:
                begin
                    x0t_reg <= rdt_reg;
                    x0v_reg <= rdv_reg;
                end
                2'b01:
                begin
                    x1t_reg <= rdt_reg;
                    x1v_reg <= rdv_reg;
                end
                2'b10:
                begin
                    y0t_reg <= rdt_reg;
                    y0v_reg <= rdv_reg;
                end
                default:
                begin
                    y1t_reg <= rdt_reg;
                    y1v_reg <= rdv_reg;
                end
            endcase
        end
    end

    tsai_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .v1     (cmd.side ? x0v_reg : y0v_reg),
        .v2     (cmd.side ? x1v_reg : y1v_reg),
        .t1     (cmd.side ? x0t_reg : y0t_reg),
        .t2     (cmd.side ? x1t_reg : y1t_reg),
        .t      (cmd.side ? y0t_reg : x0t_reg),
        .done   (i_done),
        .result (i_res)
    );

    // hold the paired head value while interpolating
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            side_reg <= cmd.side;
            keep_reg <= cmd.side ? y0v_reg : x0v_reg;
        end
        if (cmd.take)
        begin
            pend_x_reg <= side_reg ? i_res : keep_reg;
            pend_y_reg <= side_reg ? keep_reg : i_res;
        end
    end

    // pending point and output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && point_stall;
        if (cmd.take)
        begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
                out_valid_next = 1'b1;
        end
        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.take && pend_valid_reg) || cmd.flush)
        begin
            out_reg.x_value    <= pend_x_reg;
            out_reg.y_value    <= pend_y_reg;
            out_reg.last_point <= cmd.flush;
        end
    end

    assign point       = out_reg;
    assign point_valid = out_valid_reg;

    always_comb
    begin
        stat.x_gt1      = xcnt_reg > NW'(1);
        stat.y_gt1      = ycnt_reg > NW'(1);
        stat.x1_lt_y0   = x1t_reg < y0t_reg;
        stat.y1_lt_x0   = y1t_reg < x0t_reg;
        stat.x0_ge_y0   = x0t_reg >= y0t_reg;
        stat.y0_ge_x0   = y0t_reg >= x0t_reg;
        stat.done       = i_done;
        stat.out_free   = out_free;
        stat.pend_valid = pend_valid_reg;
    end

endmodule

// ===== design/tsai_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsai_ctrl: sequencing state machine
// Accepts one request, then loads queue heads, drops stale heads, pairs
// and interpolates until no pair remains or MAX_RESULTS is reached, then flushes the last point.
// ---------------------------------------------------------------------------
module tsai_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  tsai_pkg::stat_t   stat,
    output tsai_pkg::cmd_t    cmd
);

    localparam int NW = tsai_pkg::NCNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_DROPX  = 3'd3;
    localparam logic [2:0] ST_DROPY  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_WAIT   = 3'd6;
    localparam logic [2:0] ST_FLUSH  = 3'd7;

    logic [2:0]    st_reg, st_next;
    logic [2:0]    ret_reg, ret_next;
    logic [2:0]    step_reg, step_next;
    logic [NW-1:0] n_reg, n_next;
    logic          side_reg, side_next;

    assign sample_stall = (st_reg != ST_IDLE);

    always_comb
    begin
        st_next   = st_reg;
        ret_next  = ret_reg;
        step_next = step_reg;
        n_next    = n_reg;
        side_next = side_reg;
        cmd       = '0;
        cmd.side  = side_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    n_next     = '0;
                    st_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((n_reg < NW'(tsai_pkg::MAX_RESULTS)) && stat.x_gt1 && stat.y_gt1)
                begin
                    step_next = '0;
                    ret_next  = ST_DROPX;
                    st_next   = ST_LOAD;
                end
                else
                    st_next = ST_FLUSH;
            end
            ST_LOAD:
            begin
                // read x head, x next, y head, y next; last step drains
                if (step_reg != 3'd4)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_ch  = step_reg[1];
                    cmd.rd_nxt = step_reg[0];
                    step_next  = step_reg + 1'b1;
                end
                else
                    st_next = ret_reg;
            end
            ST_DROPX:
            begin
                if (stat.x_gt1 && stat.x1_lt_y0)
                begin
                    cmd.pop_x = 1'b1;
                    step_next = '0;
                    ret_next  = ST_DROPX;
                    st_next   = ST_LOAD;
                end
                else
                    st_next = ST_DROPY;
            end
            ST_DROPY:
            begin
                if (stat.y_gt1 && stat.y1_lt_x0)
                begin
                    cmd.pop_y = 1'b1;
                    step_next = '0;
                    ret_next  = ST_DROPY;
                    st_next   = ST_LOAD;
                end
                else
                    st_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.x0_ge_y0 && stat.y_gt1)
                begin
                    cmd.start = 1'b1;
                    cmd.side  = 1'b0;
                    side_next = 1'b0;
                    st_next   = ST_WAIT;
                end
                else if (stat.y0_ge_x0 && stat.x_gt1)
                begin
                    cmd.start = 1'b1;
                    cmd.side  = 1'b1;
                    side_next = 1'b1;
                    st_next   = ST_WAIT;
                end
                else
                    st_next = ST_FLUSH;
            end
            ST_WAIT:
            begin
                // hold until the point and a free output slot are ready
                if (stat.done && (!stat.pend_valid || stat.out_free))
                begin
                    cmd.take  = 1'b1;
                    cmd.pop_x = !side_reg;
                    cmd.pop_y = side_reg;
                    n_next    = n_reg + 1'b1;
                    st_next   = ST_CHECK;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                    st_next = ST_IDLE;
                else if (stat.out_free)
                begin
                    cmd.flush = 1'b1;
                    st_next   = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ret_reg  <= ST_DROPX;
            step_reg <= '0;
            n_reg    <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ret_reg  <= ret_next;
            step_reg <= step_next;
            n_reg    <= n_next;
            side_reg <= side_next;
        end
    end

endmodule

// ===== design/two_stream_time_align_interp.sv =====
// ---------------------------------------------------------------------------
// two_stream_time_align_interp: two-stream time alignment by interpolation
// Pairs x and y samples into (x, y) points at common times.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel: one timestamped x or y request per transfer; accepted
//   when sample_valid is high and sample_stall is low. The block takes one
//   request at a time and stalls until all its points have entered the output register.
//   point channel: zero or more points per request, the final one marked by
//   last_point. Points are held in an output register while point_stall is
//   high; the sequencer waits for a free slot before producing more.
//   Steps: a request is stored on acceptance; each queue head reload is four
//   reads on the single memory port plus one capture; each point takes a check,
//   a head reload, the two drop checks and the pairing decision, then the
//   interpolation unit (clamp, a 32x32 and a 32x31 partial product, a wide
//   add, a 95-step restoring divide, rounding, output). Each dropped stale
//   head adds a pop and a head reload.
//   Reset: queue counts and all control clear at once; queue contents need
//   no clearing pass.
// ---------------------------------------------------------------------------
module two_stream_time_align_interp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsai_pkg::sample_t sample,
    input  logic              sample_valid,
    output logic              sample_stall,
    output tsai_pkg::point_t  point,
    output logic              point_valid,
    input  logic              point_stall
);

    tsai_pkg::cmd_t  cmd;
    tsai_pkg::stat_t stat;

    tsai_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    tsai_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cmd         (cmd),
        .stat        (stat),
        .point       (point),
        .point_valid (point_valid),
        .point_stall (point_stall)
    );

endmodule

// ===== bench/two_stream_time_align_interp_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_stream_time_align_interp_chk: point predictor and comparator
// Watches accepted sample requests, keeps its own x and y queues, works out
// the aligned (x, y) points each request yields and compares them in order
// with the points the block hands on.
// ---------------------------------------------------------------------------
module two_stream_time_align_interp_chk #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsai_pkg::sample_t sample,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  tsai_pkg::point_t  point,
    input  logic              point_valid,
    input  logic              point_stall,
    output int                fail_count,
    output int                pending_points
);

    localparam int TW      = tsai_pkg::TIME_W;
    localparam int VW      = tsai_pkg::VAL_W;
    localparam int MAX_RES = tsai_pkg::MAX_RESULTS;

    logic [TW-1:0]        q_time [2][$];
    logic signed [VW-1:0] q_val  [2][$];
    tsai_pkg::point_t     want_points [$];

    // Linear interpolation, exact, rounding half away from zero in magnitude
    function automatic logic signed [VW-1:0] lerp_value(
        input logic signed [VW-1:0] v1, input logic signed [VW-1:0] v2,
        input logic [TW-1:0] t1, input logic [TW-1:0] t2,
        input logic [TW-1:0] t);
        logic signed [VW+1:0] dv;
        logic [VW:0]          mag;
        logic [TW:0]          span, num;
        logic [127:0]         prod, quo, rem;
        logic signed [127:0]  res;
        if (t2 <= t1)
            return v1;
        span = {1'b0, t2 - t1};
        num  = (t <= t1) ? '0 : {1'b0, t - t1};
        if (num > span)
            num = span;
        dv   = v2 - v1;
        mag  = (VW+1)'(dv < 0 ? -dv : dv);
        prod = mag * num;
        quo  = prod / span;
        rem  = prod % span;
        if (rem >= span - rem)
            quo = quo + 128'd1;
        res = dv < 0 ? $signed(v1) - $signed(quo) : $signed(v1) + $signed(quo);
        if (res > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (res < -128'sd2147483648)
            return 32'h8000_0000;
        return res[VW-1:0];
    endfunction

    // Store one sample and queue the points it releases
    task automatic align_sample(input tsai_pkg::sample_t s);
        int               ch, n;
        tsai_pkg::point_t p;
        ch = s.channel;
        n  = 0;
        if (q_time[ch].size() > 0 && s.sample_time <= q_time[ch][$])
        begin
            q_time[ch].delete();
            q_val[ch].delete();
        end
        if (q_time[ch].size() >= QUEUE_DEPTH)
        begin
            void'(q_time[ch].pop_front());
            void'(q_val[ch].pop_front());
        end
        q_time[ch].push_back(s.sample_time);
        q_val[ch].push_back(s.sample_value);
        while (n < MAX_RES && q_time[0].size() > 1 && q_time[1].size() > 1)
        begin
            // drop stale heads
            while (q_time[0].size() > 1 && q_time[0][1] < q_time[1][0])
            begin
                void'(q_time[0].pop_front());
                void'(q_val[0].pop_front());
            end
            while (q_time[1].size() > 1 && q_time[1][1] < q_time[0][0])
            begin
                void'(q_time[1].pop_front());
                void'(q_val[1].pop_front());
            end
            p.last_point = 1'b0;
            if (q_time[0][0] >= q_time[1][0] && q_time[1].size() > 1)
            begin
                p.x_value = q_val[0][0];
                p.y_value = lerp_value(q_val[1][0], q_val[1][1], q_time[1][0],
                                       q_time[1][1], q_time[0][0]);
                void'(q_time[0].pop_front());
                void'(q_val[0].pop_front());
            end
            else if (q_time[1][0] >= q_time[0][0] && q_time[0].size() > 1)
            begin
                p.y_value = q_val[1][0];
                p.x_value = lerp_value(q_val[0][0], q_val[0][1], q_time[0][0],
                                       q_time[0][1], q_time[1][0]);
                void'(q_time[1].pop_front());
                void'(q_val[1].pop_front());
            end
            else
                break;
            want_points.push_back(p);
            n++;
        end
        if (n > 0)
            want_points[$].last_point = 1'b1;
    endtask

    // Watch both channels and compare points
    always @(posedge clk or negedge rst_n)
    begin
        tsai_pkg::point_t w;
        if (!rst_n)
        begin
            fail_count = 0;
            want_points.delete();
            for (int c = 0; c < 2; c++)
            begin
                q_time[c].delete();
                q_val[c].delete();
            end
            pending_points = 0;
        end
        else
        begin
            if (point_valid && !point_stall)
            begin
                if (want_points.size() == 0)
                begin
                    $error("unexpected point x=%0d y=%0d", point.x_value, point.y_value);
                    fail_count++;
                end
                else
                begin
                    w = want_points.pop_front();
                    if (point.x_value !== w.x_value)
                    begin
                        $error("x_value expected %0d got %0d", w.x_value, point.x_value);
                        fail_count++;
                    end
                    if (point.y_value !== w.y_value)
                    begin
                        $error("y_value expected %0d got %0d", w.y_value, point.y_value);
                        fail_count++;
                    end
                    if (point.last_point !== w.last_point)
                    begin
                        $error("last_point expected %0b got %0b", w.last_point,
                               point.last_point);
                        fail_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                align_sample(sample);
            pending_points = want_points.size();
        end
    end

endmodule

// ===== bench/two_stream_time_align_interp_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_stream_time_align_interp_tb: stimulus and verdict
// Sends directed and random x/y sample requests, mostly with rising times
// and occasional time resets, stalls the point side at random and once for
// a long stretch, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module two_stream_time_align_interp_tb;

    localparam int TW          = tsai_pkg::TIME_W;
    localparam int VW          = tsai_pkg::VAL_W;
    localparam int N_RANDOM    = 330;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    logic              clk;
    logic              rst_n;
    tsai_pkg::sample_t sample;
    logic              sample_valid;
    logic              sample_stall;
    tsai_pkg::point_t  point;
    logic              point_valid;
    logic              point_stall;
    int                fail_count;
    int                pending_points;
    int                cycle_count;
    bit                calm;
    bit                hold_off;
    logic [TW-1:0]     clock_ns [2];

    two_stream_time_align_interp u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .point        (point),
        .point_valid  (point_valid),
        .point_stall  (point_stall)
    );

    two_stream_time_align_interp_chk u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .point          (point),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .fail_count     (fail_count),
        .pending_points (pending_points)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the point side at random, not while calm, fully during hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            point_stall <= 1'b0;
        else if (hold_off)
            point_stall <= 1'b1;
        else
            point_stall <= !calm && ($urandom_range(99) < 13);
    end

    // Hold one request until accepted, with random gaps before it
    task automatic send_sample(input bit ch, input logic [TW-1:0] t,
                               input logic signed [VW-1:0] v);
        while (!calm && $urandom_range(99) < 13)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid        <= 1'b1;
        sample.channel      <= ch;
        sample.sample_time  <= t;
        sample.sample_value <= v;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        clock_ns[ch] = t;
    endtask

    // Advance one channel's time by a random step
    task automatic send_next(input bit ch, input logic signed [VW-1:0] v);
        logic [TW-1:0] step;
        case ($urandom_range(3))
            0: step = TW'($urandom_range(1, 4));
            1: step = TW'($urandom_range(1, 1000));
            2: step = TW'({$urandom, $urandom});
            default: step = TW'($urandom);
        endcase
        step = (step >> $urandom_range(40)) | TW'(1);
        if (clock_ns[ch] > TIME_MAX - step)
            step = TW'(1);
        send_sample(ch, clock_ns[ch] + step, v);
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VW'($urandom_range(200) - 100);
            default: return VW'($urandom);
        endcase
    endfunction

    // Long receiver hold-off while samples keep coming
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (4000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        logic [TW-1:0] base;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        calm         = 1'b0;
        clock_ns[0]  = '0;
        clock_ns[1]  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of value, equal heads, repeated time, time extremes
        send_sample(0, 0, 32'h8000_0000);
        send_sample(1, 0, 32'h7FFF_FFFF);
        send_sample(0, 10, 32'h7FFF_FFFF);
        send_sample(1, 10, 32'h8000_0000);
        send_sample(0, 15, 5);
        send_sample(1, 13, -7);
        send_sample(1, 13, 3);
        send_sample(1, 20, 9);
        send_sample(0, 19, 0);
        send_sample(0, 25, -1);
        send_sample(1, 30, 2);
        base = TIME_MAX - TW'(40);
        send_sample(0, base, 100);
        send_sample(1, base + TW'(1), -100);
        send_sample(0, base + TW'(3), 101);
        send_sample(1, base + TW'(5), 32'h7FFF_FFFF);
        send_sample(0, TIME_MAX, 32'h8000_0000);
        send_sample(1, TIME_MAX, 1);
        // fill one queue past its depth before pairing
        for (int i = 0; i < 20; i++)
            send_sample(0, TW'(i + 1), VW'(i * 3 - 17));
        send_sample(1, 2, 4);
        send_sample(1, 25, 40);

        // Random: mostly rising interleaved streams, some time resets
        clock_ns[0] = TW'($urandom);
        clock_ns[1] = clock_ns[0] + TW'($urandom_range(50));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 150 && i < 200);
            if ($urandom_range(99) < 4)
                send_sample(1'($urandom_range(1)), TW'({$urandom, $urandom}),
                            pick_value());
            else if ($urandom_range(99) < 2)
            begin
                clock_ns[0] = TW'($urandom_range(1000));
                clock_ns[1] = clock_ns[0];
                send_sample(1'($urandom_range(1)), clock_ns[0], pick_value());
            end
            else
                send_next(clock_ns[0] > clock_ns[1] ? 1'b1 :
                          clock_ns[1] > clock_ns[0] ? 1'b0 : 1'($urandom_range(1)),
                          pick_value());
        end
        sample_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then settle
        while (pending_points != 0 || hold_off)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
